[hw/rtl/pfd_pkg.sv]
`default_nettype none

package pfd_pkg;

  localparam int unsigned SIDE = 5;
  localparam int unsigned CELLS = 25;
  localparam int unsigned LETTER_W = 5;
  localparam int unsigned WIDE_W = 60;
  localparam int unsigned LOW_CELLS = 12;
  localparam int unsigned POS_W = 3;
  localparam int unsigned CFG_INDEX_W = 2;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [WIDE_W-1:0] cfg_data_t;
  typedef letter_t [CELLS-1:0] square_t;

  localparam cfg_index_t REG_CELLS_LOW = 2'd0;
  localparam cfg_index_t REG_CELLS_MID = 2'd1;
  localparam cfg_index_t REG_CELL_LAST = 2'd2;

  typedef struct packed {
    logic found;
    pos_t row;
    pos_t col;
  } lane_hit_t;

  typedef struct packed {
    letter_t first_plain_letter;
    letter_t second_plain_letter;
    logic letter_missing;
  } plain_pair_t;

endpackage

`default_nettype wire

[hw/rtl/pfd_ifs.sv]
`default_nettype none

interface pfd_cipher_if;
  import pfd_pkg::*;
  logic valid;
  logic ready;
  letter_t first_cipher_letter;
  letter_t second_cipher_letter;
  modport source (output valid, first_cipher_letter, second_cipher_letter, input ready);
  modport sink (input valid, first_cipher_letter, second_cipher_letter, output ready);
endinterface

interface pfd_plain_if;
  import pfd_pkg::*;
  logic valid;
  logic ready;
  letter_t first_plain_letter;
  letter_t second_plain_letter;
  logic letter_missing;
  modport source (output valid, first_plain_letter, second_plain_letter, letter_missing,
                  input ready);
  modport sink (input valid, first_plain_letter, second_plain_letter, letter_missing,
                output ready);
endinterface

interface pfd_cfg_if;
  import pfd_pkg::*;
  logic valid;
  logic ready;
  cfg_index_t index;
  cfg_data_t data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/pfd_lane.sv]
`default_nettype none

module pfd_lane (
  input  pfd_pkg::letter_t   letter,
  input  pfd_pkg::square_t   cells,
  output pfd_pkg::lane_hit_t hit
);
  import pfd_pkg::*;

  // Scan from the last cell down so that the lowest matching cell wins.
  always_comb begin
    hit = '0;
    for (int r = SIDE - 1; r >= 0; r--) begin
      for (int c = SIDE - 1; c >= 0; c--) begin
        if (cells[r * SIDE + c] == letter) begin
          hit.found = 1'b1;
          hit.row = POS_W'(r);
          hit.col = POS_W'(c);
        end
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/pfd_merge.sv]
`default_nettype none

module pfd_merge (
  input  pfd_pkg::lane_hit_t   hit_a,
  input  pfd_pkg::lane_hit_t   hit_b,
  input  pfd_pkg::square_t     cells,
  output pfd_pkg::plain_pair_t result
);
  import pfd_pkg::*;

  typedef logic [LETTER_W-1:0] cell_idx_t;

  function automatic pos_t step_back(input pos_t p);
    step_back = (p == '0) ? POS_W'(SIDE - 1) : p - POS_W'(1);
  endfunction

  function automatic cell_idx_t cell_index(input pos_t row, input pos_t col);
    cell_idx_t r5;
    r5 = {2'b00, row};
    cell_index = (r5 << 2) + r5 + {2'b00, col};
  endfunction

  pos_t q1_row, q1_col, q2_row, q2_col;
  cell_idx_t idx1, idx2;
  letter_t letter1, letter2;

  always_comb begin
    if (hit_a.row == hit_b.row) begin
      q1_row = hit_a.row;
      q1_col = step_back(hit_a.col);
      q2_row = hit_b.row;
      q2_col = step_back(hit_b.col);
    end else if (hit_a.col == hit_b.col) begin
      q1_row = step_back(hit_a.row);
      q1_col = hit_a.col;
      q2_row = step_back(hit_b.row);
      q2_col = hit_b.col;
    end else begin
      q1_row = hit_a.row;
      q1_col = hit_b.col;
      q2_row = hit_b.row;
      q2_col = hit_a.col;
    end
    idx1 = cell_index(q1_row, q1_col);
    idx2 = cell_index(q2_row, q2_col);
  end

  always_comb begin
    letter1 = '0;
    letter2 = '0;
    for (int k = 0; k < CELLS; k++) begin
      if (idx1 == cell_idx_t'(k)) letter1 = cells[k];
      if (idx2 == cell_idx_t'(k)) letter2 = cells[k];
    end
  end

  always_comb begin
    if (!hit_a.found || !hit_b.found) begin
      result.first_plain_letter = '0;
      result.second_plain_letter = '0;
      result.letter_missing = 1'b1;
    end else begin
      result.first_plain_letter = letter1;
      result.second_plain_letter = letter2;
      result.letter_missing = 1'b0;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/playfair_digraph_decrypt_top.sv]
`default_nettype none
// Channel  Direction  Payload
// cipher   in         first_cipher_letter, second_cipher_letter
// plain    out        first_plain_letter, second_plain_letter, letter_missing
// cfg      in         index, data (square cell registers)
//
// One letter pair is taken every cycle unless a stall on plain backs up into cipher.
// The two search lanes are registered, then the merge stage feeds the output register.
// Reset clears the key square to zero and empties the pipeline; cfg is always ready.
// A stall on plain holds the output register and backs up into cipher only when full.

module playfair_digraph_decrypt_top (
  input wire logic clk,
  input wire logic rst,
  pfd_cipher_if.sink  cipher,
  pfd_plain_if.source plain,
  pfd_cfg_if.sink     cfg
);
  import pfd_pkg::*;

  logic [WIDE_W-1:0] square_cells_low;
  logic [WIDE_W-1:0] square_cells_mid;
  letter_t square_cell_last;
  square_t cells;

  lane_hit_t lane_a_hit, lane_b_hit;
  lane_hit_t s1_hit_a, s1_hit_b;
  logic s1_valid;
  plain_pair_t merged;
  plain_pair_t out_data;
  logic out_valid;
  logic advance_out, advance_s1;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      square_cells_low <= '0;
      square_cells_mid <= '0;
      square_cell_last <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_CELLS_LOW: square_cells_low <= cfg.data;
        REG_CELLS_MID: square_cells_mid <= cfg.data;
        REG_CELL_LAST: square_cell_last <= cfg.data[LETTER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < LOW_CELLS; k++) begin
      cells[k] = square_cells_low[k * LETTER_W +: LETTER_W];
      cells[k + LOW_CELLS] = square_cells_mid[k * LETTER_W +: LETTER_W];
    end
    cells[CELLS-1] = square_cell_last;
  end

  pfd_lane u_lane_a (
    .letter (cipher.first_cipher_letter),
    .cells  (cells),
    .hit    (lane_a_hit)
  );

  pfd_lane u_lane_b (
    .letter (cipher.second_cipher_letter),
    .cells  (cells),
    .hit    (lane_b_hit)
  );

  assign advance_out = !out_valid || plain.ready;
  assign advance_s1 = !s1_valid || advance_out;
  assign cipher.ready = advance_s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance_s1) begin
      s1_valid <= cipher.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance_s1 && cipher.valid) begin
      s1_hit_a <= lane_a_hit;
      s1_hit_b <= lane_b_hit;
    end
  end

  pfd_merge u_merge (
    .hit_a  (s1_hit_a),
    .hit_b  (s1_hit_b),
    .cells  (cells),
    .result (merged)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance_out) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance_out && s1_valid) begin
      out_data <= merged;
    end
  end

  assign plain.valid = out_valid;
  assign plain.first_plain_letter = out_data.first_plain_letter;
  assign plain.second_plain_letter = out_data.second_plain_letter;
  assign plain.letter_missing = out_data.letter_missing;

endmodule

`default_nettype wire

[hw/rtl/pfd_checker.sv]
`default_nettype none

module pfd_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire pfd_pkg::letter_t out_first,
  input wire pfd_pkg::letter_t out_second,
  input wire logic out_missing
);
  import pfd_pkg::*;

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  // A result waiting on a stalled sink must stay put.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_first) && $stable(out_second)
      && $stable(out_missing))
    else $error("result changed while stalled");

  // The pipeline is empty in the cycle after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  // An error result always carries zero letters.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_missing |-> out_first == '0 && out_second == '0)
    else $error("missing letter with nonzero plaintext");

  // With the sink ready once the lane register holds it, a transfer's result reaches the output register.
  assert property (@(posedge clk) disable iff (rst)
    in_xfer ##1 out_ready |=> out_valid)
    else $error("result did not appear after transfer");

endmodule

bind playfair_digraph_decrypt_top pfd_checker u_pfd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (cipher.valid),
  .in_ready    (cipher.ready),
  .out_valid   (plain.valid),
  .out_ready   (plain.ready),
  .out_first   (plain.first_plain_letter),
  .out_second  (plain.second_plain_letter),
  .out_missing (plain.letter_missing)
);

`default_nettype wire
